// ===== sv/mfjs_pkg.sv =====
// Shared types, constants and codes for the multilevel feedback job scheduler.
package mfjs_pkg;

  localparam int MAX_JOBS = 16;
  localparam int NUM_Q    = 3;
  localparam int SW       = $clog2(MAX_JOBS);
  localparam int CW       = $clog2(MAX_JOBS + 1);
  localparam int QD       = NUM_Q * MAX_JOBS;
  localparam int QAW      = $clog2(QD);

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ENQ    = 3'd1;
  localparam logic [2:0] CMD_DEQ    = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_DONE   = 3'd4;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam logic [1:0] CFG_AGING  = 2'd0;
  localparam logic [1:0] CFG_SLICE1 = 2'd1;
  localparam logic [1:0] CFG_SLICE2 = 2'd2;
  localparam logic [1:0] CFG_SLICE3 = 2'd3;

  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] owner;
    logic [1:0]  level;
    logic [3:0]  wait_cnt;
    logic [31:0] run;
    logic [2:0]  slice;
  } slot_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] job_id;
    logic [15:0] job_owner;
    logic [31:0] run_ticks;
    logic [3:0]  wait_ticks;
    logic [1:0]  level;
    logic        is_running;
    logic [15:0] stopped_job_id;
    logic [15:0] resumed_job_id;
    logic [1:0]  error;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [3:0] aging;
    logic [2:0] slice1;
    logic [2:0] slice2;
    logic [2:0] slice3;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_UPD, S_AGE_Q, S_AGE_S, S_AGE_W, S_RUN_RD, S_RUN_W,
    S_SEL, S_SEL_D, S_SEL_W, S_RM, S_RM_W, S_CMD, S_ENQ, S_ENQ_FIN,
    S_DQ, S_DQ_Q, S_DQ_S, S_DQ_C, S_DQ_END, S_ST, S_ST_Q, S_ST_S, S_ST_D,
    S_EMIT
  } state_e;

endpackage

// ===== sv/mfjs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfjs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                  wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mfjs_ctrl.sv =====
// Scheduler sequencer: walks the slot table and queue memories per request.
module mfjs_ctrl import mfjs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [1:0]  default_priority_i,
  input  logic [15:0] owner_i,
  input  logic [15:0] target_job_id_i,
  input  cfg_t        cfg_i,
  input  logic        emit_ready_i,
  output logic        emit_valid_o,
  output res_t        emit_res_o
);

  state_e state_q, state_d, nxt_q, nxt_d, ret_q, ret_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [1:0]  prio_q, prio_d;
  logic [15:0] own_q, own_d, tgt_q, tgt_d;
  logic [1:0]  l_q, l_d;
  logic [CW-1:0] i_q, i_d, rem_q, rem_d;
  logic [SW-1:0] s_q, s_d, rslot_q, rslot_d, news_q, news_d;
  logic rvalid_q, rvalid_d, rdone_q, rdone_d, pass_q, pass_d;
  logic pre_q, pre_d, isr_q, isr_d;
  logic [15:0] rid_q, rid_d, idc_q, idc_d, st_q, st_d, st2_q, st2_d, rs_q, rs_d;
  logic [1:0]  err_q, err_d;
  logic [MAX_JOBS-1:0] val_q, val_d;
  logic [CW-1:0] cnt_q [NUM_Q];
  logic [CW-1:0] cnt_d [NUM_Q];
  res_t res_q, res_d;

  logic          sram_we;
  logic [SW-1:0] sram_waddr, sram_raddr;
  slot_t         sram_wdata, sram_rdata;
  logic [$bits(slot_t)-1:0] sram_rvec;
  logic          qram_we;
  logic [QAW-1:0] qram_waddr, qram_raddr;
  logic [SW-1:0] qram_wdata, qram_rdata;

  // combinational helpers
  logic [CW-1:0] i_nx;
  logic [15:0]   rid_now, id_nx;
  logic          free_found, sel_found;
  logic [SW-1:0] free_idx;
  logic [1:0]    sel_l;
  logic          hit;
  logic [1:0]    push_l;
  logic [3:0]    w_inc;

  function automatic logic [QAW-1:0] qaddr(input logic [1:0] l, input logic [SW-1:0] i);
    return QAW'(int'(l) * MAX_JOBS + int'(i));
  endfunction

  function automatic res_t report(input logic [15:0] id, input logic [15:0] st,
                                  input logic [15:0] rs, input logic [1:0] err,
                                  input logic last);
    res_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.job_id = id;
    r.stopped_job_id = st;
    r.resumed_job_id = rs;
    r.error = err;
    r.last = last;
    return r;
  endfunction

  mfjs_ram #(.W($bits(slot_t)), .D(MAX_JOBS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sram_we),
    .waddr_i (sram_waddr),
    .wdata_i (sram_wdata),
    .raddr_i (sram_raddr),
    .rdata_o (sram_rvec)
  );
  assign sram_rdata = slot_t'(sram_rvec);

  mfjs_ram #(.W(SW), .D(QD)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qram_waddr),
    .wdata_i (qram_wdata),
    .raddr_i (qram_raddr),
    .rdata_o (qram_rdata)
  );

  assign i_nx    = i_q + 1'b1;
  assign rid_now = rvalid_q ? rid_q : 16'd0;
  assign id_nx   = (idc_q == 16'hFFFF) ? 16'd1 : idc_q + 16'd1;
  assign in_stall_o   = (state_q != S_IDLE);
  assign emit_valid_o = (state_q == S_EMIT) && emit_ready_i;
  assign emit_res_o   = res_q;

  // lowest free slot and first non-empty queue
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int f = MAX_JOBS - 1; f >= 0; f--) begin
      if (!val_q[f]) begin
        free_found = 1'b1;
        free_idx   = SW'(f);
      end
    end
    sel_found = 1'b0;
    sel_l     = '0;
    for (int q = NUM_Q - 1; q >= 0; q--) begin
      if (cnt_q[q] != '0) begin
        sel_found = 1'b1;
        sel_l     = 2'(q);
      end
    end
  end

  // running job expiry and demotion target
  always_comb begin
    hit = pre_q ||
          (sram_rdata.level == 2'd3 && sram_rdata.slice == cfg_i.slice3) ||
          (sram_rdata.level == 2'd2 && sram_rdata.slice == cfg_i.slice2) ||
          (sram_rdata.level == 2'd1 && sram_rdata.slice == cfg_i.slice1);
    push_l = (sram_rdata.level <= 2'd1) ? 2'd1 : 2'd2;
    w_inc  = (sram_rdata.wait_cnt < 4'd15) ? sram_rdata.wait_cnt + 4'd1
                                           : sram_rdata.wait_cnt;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = (command_i == CMD_DONE) ? S_EMIT : S_UPD;
      S_UPD:    state_d = S_AGE_Q;
      S_AGE_Q: begin
        if (i_q >= cnt_q[l_q]) begin
          if (l_q == 2'd2) state_d = S_RUN_RD;
        end else begin
          state_d = S_AGE_S;
        end
      end
      S_AGE_S:  state_d = S_AGE_W;
      S_AGE_W:  state_d = S_AGE_Q;
      S_RUN_RD: state_d = rvalid_q ? S_RUN_W : S_SEL;
      S_RUN_W:  state_d = S_SEL;
      S_SEL: begin
        if (pass_q) state_d = S_ENQ_FIN;
        else if (!rvalid_q && sel_found) state_d = S_SEL_D;
        else state_d = S_CMD;
      end
      S_SEL_D:  state_d = S_SEL_W;
      S_SEL_W:  state_d = S_RM;
      S_RM:     state_d = (i_nx < cnt_q[l_q]) ? S_RM_W : ret_q;
      S_RM_W:   state_d = S_RM;
      S_CMD: begin
        case (cmd_q)
          CMD_DEQ:    state_d = S_DQ;
          CMD_STATUS: state_d = S_ST;
          default:    state_d = S_EMIT;
        endcase
      end
      S_ENQ:    state_d = free_found ? S_UPD : S_EMIT;
      S_ENQ_FIN: state_d = S_EMIT;
      S_DQ:     state_d = (rvalid_q && rid_q == tgt_q) ? S_DQ_END : S_DQ_Q;
      S_DQ_Q: begin
        if (i_q >= cnt_q[l_q]) begin
          if (l_q == 2'd2) state_d = S_DQ_END;
        end else begin
          state_d = S_DQ_S;
        end
      end
      S_DQ_S:   state_d = S_DQ_C;
      S_DQ_C:   state_d = (sram_rdata.job_id == tgt_q) ? S_RM : S_DQ_Q;
      S_DQ_END: state_d = S_EMIT;
      S_ST: begin
        if (rem_q == '0) state_d = S_EMIT;
        else if (rvalid_q) state_d = S_ST_D;
        else state_d = S_ST_Q;
      end
      S_ST_Q: begin
        if (i_q >= cnt_q[l_q]) begin
          if (l_q == 2'd2) state_d = S_IDLE;
        end else begin
          state_d = S_ST_S;
        end
      end
      S_ST_S:   state_d = S_ST_D;
      S_ST_D:   state_d = S_EMIT;
      S_EMIT:   if (emit_ready_i) state_d = nxt_q;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_d = cmd_q; prio_d = prio_q; own_d = own_q; tgt_d = tgt_q;
    l_d = l_q; i_d = i_q; rem_d = rem_q; s_d = s_q;
    rslot_d = rslot_q; news_d = news_q; rvalid_d = rvalid_q; rdone_d = rdone_q;
    pass_d = pass_q; pre_d = pre_q; isr_d = isr_q;
    rid_d = rid_q; idc_d = idc_q; st_d = st_q; st2_d = st2_q; rs_d = rs_q;
    err_d = err_q; val_d = val_q; cnt_d = cnt_q; res_d = res_q;
    nxt_d = nxt_q; ret_d = ret_q;
    sram_we = 1'b0; sram_waddr = s_q; sram_wdata = sram_rdata; sram_raddr = '0;
    qram_we = 1'b0; qram_waddr = '0; qram_wdata = '0; qram_raddr = '0;
    unique case (state_q)
      // latch request, answer a finish notice at once
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = command_i; prio_d = default_priority_i;
          own_d = owner_i; tgt_d = target_job_id_i;
          pass_d = 1'b0; pre_d = 1'b0;
          st_d = '0; st2_d = '0; rs_d = '0;
          if (command_i == CMD_DONE) begin
            if (rvalid_q) rdone_d = 1'b1;
            res_d = report(rid_now, 16'd0, 16'd0, ERR_OK, 1'b1);
            nxt_d = S_IDLE;
          end
        end
      end
      // drop a finished running job
      S_UPD: begin
        if (rvalid_q && rdone_q) begin
          val_d[rslot_q] = 1'b0;
          rvalid_d = 1'b0;
          rdone_d = 1'b0;
        end
        l_d = '0; i_d = '0;
      end
      S_AGE_Q: begin
        if (i_q >= cnt_q[l_q]) begin
          if (l_q != 2'd2) begin
            l_d = l_q + 2'd1; i_d = '0;
          end
        end else begin
          qram_raddr = qaddr(l_q, i_q[SW-1:0]);
        end
      end
      S_AGE_S: begin
        s_d = qram_rdata;
        sram_raddr = qram_rdata;
      end
      // age one queued job
      S_AGE_W: begin
        sram_we = 1'b1;
        sram_wdata = sram_rdata;
        if (w_inc >= cfg_i.aging && sram_rdata.level > 2'd1) begin
          sram_wdata.level = sram_rdata.level - 2'd1;
          sram_wdata.wait_cnt = 4'd0;
        end else begin
          sram_wdata.wait_cnt = w_inc;
        end
        i_d = i_nx;
      end
      S_RUN_RD: sram_raddr = rslot_q;
      // advance or demote the running job
      S_RUN_W: begin
        sram_we = 1'b1;
        sram_waddr = rslot_q;
        sram_wdata = sram_rdata;
        if (hit) begin
          sram_wdata.slice = 3'd0;
          sram_wdata.level = (push_l == 2'd1) ? 2'd2 : 2'd3;
          sram_wdata.wait_cnt = 4'd0;
          if (cnt_q[push_l] < CW'(MAX_JOBS)) begin
            qram_we = 1'b1;
            qram_waddr = qaddr(push_l, cnt_q[push_l][SW-1:0]);
            qram_wdata = rslot_q;
            cnt_d[push_l] = cnt_q[push_l] + 1'b1;
          end
          rvalid_d = 1'b0;
          if (pass_q) st2_d = rid_q;
          else st_d = rid_q;
        end else begin
          if (sram_rdata.run != 32'hFFFF_FFFF) sram_wdata.run = sram_rdata.run + 32'd1;
          sram_wdata.slice = sram_rdata.slice + 3'd1;
        end
      end
      S_SEL: begin
        qram_raddr = qaddr(sel_l, '0);
        l_d = sel_l;
      end
      S_SEL_D: begin
        s_d = qram_rdata;
        sram_raddr = qram_rdata;
        rslot_d = qram_rdata;
        rvalid_d = 1'b1;
        rdone_d = 1'b0;
      end
      // start the queue head
      S_SEL_W: begin
        sram_we = 1'b1;
        sram_wdata = sram_rdata;
        sram_wdata.slice = 3'd0;
        rid_d = sram_rdata.job_id;
        rs_d = sram_rdata.job_id;
        i_d = '0;
        ret_d = S_CMD;
      end
      // close the gap left by a removed entry
      S_RM: begin
        if (i_nx < cnt_q[l_q]) begin
          qram_raddr = qaddr(l_q, i_nx[SW-1:0]);
        end else if (cnt_q[l_q] != '0) begin
          cnt_d[l_q] = cnt_q[l_q] - 1'b1;
        end
      end
      S_RM_W: begin
        qram_we = 1'b1;
        qram_waddr = qaddr(l_q, i_q[SW-1:0]);
        qram_wdata = qram_rdata;
        i_d = i_nx;
      end
      S_CMD: begin
        case (cmd_q)
          CMD_ENQ: begin
            res_d = report(rid_now, st_q, rs_q, ERR_OK, 1'b0);
            nxt_d = S_ENQ;
          end
          CMD_DEQ: ;
          CMD_STATUS: begin
            rem_d = CW'(rvalid_q) + cnt_q[0] + cnt_q[1] + cnt_q[2];
          end
          default: begin
            res_d = report(rid_now, st_q, rs_q, ERR_OK, 1'b1);
            nxt_d = S_IDLE;
          end
        endcase
      end
      // create the new job, then rerun the update with preemption
      S_ENQ: begin
        if (!free_found) begin
          res_d = report(16'd0, 16'd0, 16'd0, ERR_FULL, 1'b1);
          nxt_d = S_IDLE;
        end else begin
          idc_d = id_nx;
          val_d[free_idx] = 1'b1;
          sram_we = 1'b1;
          sram_waddr = free_idx;
          sram_wdata = '0;
          sram_wdata.job_id = id_nx;
          sram_wdata.owner = own_q;
          sram_wdata.level = (prio_q == 2'd0) ? 2'd1 : prio_q;
          news_d = free_idx;
          pass_d = 1'b1;
          pre_d = rvalid_q;
        end
      end
      S_ENQ_FIN: begin
        rslot_d = news_q;
        rvalid_d = 1'b1;
        rdone_d = 1'b0;
        rid_d = idc_q;
        res_d = report(idc_q, st2_q, idc_q, ERR_OK, 1'b1);
        nxt_d = S_IDLE;
      end
      // dequeue: running job first, then the queues
      S_DQ: begin
        if (rvalid_q && rid_q == tgt_q) begin
          val_d[rslot_q] = 1'b0;
          rvalid_d = 1'b0;
          rdone_d = 1'b0;
          err_d = ERR_OK;
        end else begin
          err_d = ERR_NOT_FOUND;
          l_d = '0; i_d = '0;
        end
      end
      S_DQ_Q: begin
        if (i_q >= cnt_q[l_q]) begin
          if (l_q != 2'd2) begin
            l_d = l_q + 2'd1; i_d = '0;
          end
        end else begin
          qram_raddr = qaddr(l_q, i_q[SW-1:0]);
        end
      end
      S_DQ_S: begin
        s_d = qram_rdata;
        sram_raddr = qram_rdata;
      end
      S_DQ_C: begin
        if (sram_rdata.job_id == tgt_q) begin
          val_d[s_q] = 1'b0;
          err_d = ERR_OK;
          ret_d = S_DQ_END;
        end else begin
          i_d = i_nx;
        end
      end
      S_DQ_END: begin
        res_d = report(rid_now, st_q, rs_q, err_q, 1'b1);
        nxt_d = S_IDLE;
      end
      // status listing
      S_ST: begin
        l_d = '0; i_d = '0;
        if (rem_q == '0) begin
          res_d = report(16'd0, st_q, rs_q, ERR_OK, 1'b1);
          nxt_d = S_IDLE;
        end else if (rvalid_q) begin
          sram_raddr = rslot_q;
          isr_d = 1'b1;
        end else begin
          isr_d = 1'b0;
        end
      end
      S_ST_Q: begin
        if (i_q >= cnt_q[l_q]) begin
          if (l_q != 2'd2) begin
            l_d = l_q + 2'd1; i_d = '0;
          end
        end else begin
          qram_raddr = qaddr(l_q, i_q[SW-1:0]);
          isr_d = 1'b0;
        end
      end
      S_ST_S: sram_raddr = qram_rdata;
      S_ST_D: begin
        res_d = '0;
        res_d.kind = KIND_ENTRY;
        res_d.job_id = sram_rdata.job_id;
        res_d.job_owner = sram_rdata.owner;
        res_d.run_ticks = sram_rdata.run;
        res_d.wait_ticks = sram_rdata.wait_cnt;
        res_d.level = sram_rdata.level;
        res_d.is_running = isr_q;
        res_d.stopped_job_id = st_q;
        res_d.resumed_job_id = rs_q;
        res_d.error = ERR_OK;
        res_d.last = (rem_q == CW'(1));
        rem_d = rem_q - 1'b1;
        if (!isr_q) i_d = i_nx;
        isr_d = 1'b0;
        nxt_d = (rem_q == CW'(1)) ? S_IDLE : S_ST_Q;
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; nxt_q <= S_IDLE; ret_q <= S_IDLE;
      cmd_q <= '0; prio_q <= '0; own_q <= '0; tgt_q <= '0;
      l_q <= '0; i_q <= '0; rem_q <= '0; s_q <= '0;
      rslot_q <= '0; news_q <= '0; rvalid_q <= 1'b0; rdone_q <= 1'b0;
      pass_q <= 1'b0; pre_q <= 1'b0; isr_q <= 1'b0;
      rid_q <= '0; idc_q <= '0; st_q <= '0; st2_q <= '0; rs_q <= '0;
      err_q <= '0; val_q <= '0; res_q <= '0;
      for (int q = 0; q < NUM_Q; q++) cnt_q[q] <= '0;
    end else begin
      state_q <= state_d; nxt_q <= nxt_d; ret_q <= ret_d;
      cmd_q <= cmd_d; prio_q <= prio_d; own_q <= own_d; tgt_q <= tgt_d;
      l_q <= l_d; i_q <= i_d; rem_q <= rem_d; s_q <= s_d;
      rslot_q <= rslot_d; news_q <= news_d; rvalid_q <= rvalid_d; rdone_q <= rdone_d;
      pass_q <= pass_d; pre_q <= pre_d; isr_q <= isr_d;
      rid_q <= rid_d; idc_q <= idc_d; st_q <= st_d; st2_q <= st2_d; rs_q <= rs_d;
      err_q <= err_d; val_q <= val_d; res_q <= res_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/multilevel_feedback_job_scheduler.sv =====
// Three-level feedback job scheduler: config registers, sequencer and result register.
// A tick ages every queued job, updates the running job and, when none runs, takes a
// queue head and shifts that queue up; a finish notice skips this walk. Enqueue adds a
// second pass with preemption; status lists the running job, then each queued one;
// dequeue searches the running job, then the queues. Output stalls hold the sequencer.
// Reset clears control state, counts, valid bits, config and result registers only.
module multilevel_feedback_job_scheduler import mfjs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [1:0]  default_priority_i,
  input  logic [15:0] owner_i,
  input  logic [15:0] target_job_id_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] job_id_o,
  output logic [15:0] job_owner_o,
  output logic [31:0] run_ticks_o,
  output logic [3:0]  wait_ticks_o,
  output logic [1:0]  level_o,
  output logic        is_running_o,
  output logic [15:0] stopped_job_id_o,
  output logic [15:0] resumed_job_id_o,
  output logic [1:0]  error_o,
  output logic        last_o
);

  cfg_t cfg_q, cfg_d;
  res_t out_q, emit_res;
  logic out_valid_q, emit_valid, emit_ready;

  // config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_AGING:  cfg_d.aging  = cfg_data_i;
        CFG_SLICE1: cfg_d.slice1 = cfg_data_i[2:0];
        CFG_SLICE2: cfg_d.slice2 = cfg_data_i[2:0];
        CFG_SLICE3: cfg_d.slice3 = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{aging: 4'd10, slice1: 3'd1, slice2: 3'd2, slice3: 3'd5};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mfjs_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .default_priority_i (default_priority_i),
    .owner_i            (owner_i),
    .target_job_id_i    (target_job_id_i),
    .cfg_i              (cfg_q),
    .emit_ready_i       (emit_ready),
    .emit_valid_o       (emit_valid),
    .emit_res_o         (emit_res)
  );

  // hold a result until the consumer takes it
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else if (emit_valid) begin
      out_valid_q <= 1'b1;
      out_q <= emit_res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign job_id_o         = out_q.job_id;
  assign job_owner_o      = out_q.job_owner;
  assign run_ticks_o      = out_q.run_ticks;
  assign wait_ticks_o     = out_q.wait_ticks;
  assign level_o          = out_q.level;
  assign is_running_o     = out_q.is_running;
  assign stopped_job_id_o = out_q.stopped_job_id;
  assign resumed_job_id_o = out_q.resumed_job_id;
  assign error_o          = out_q.error;
  assign last_o           = out_q.last;

endmodule
